/* sv/ostm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostm_pkg
// Shared types and constants for the ordered software timer manager.
// ----------------------------------------------------------------------------
package ostm_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_FIRES_DEF  = 63;

    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] HALF_RANGE = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_START   = 2'd1,
        OP_STOP    = 2'd2,
        OP_PROCESS = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACT,
        ST_SCAN,
        ST_DECIDE,
        ST_FIRE,
        ST_RESP_RD,
        ST_RESP_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  timer_id;
        logic        periodic;
        logic [63:0] timeout;
        logic [63:0] now;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic        status;
        logic [3:0]  fired_id;
        logic [63:0] compare_value;
        logic        compare_armed;
        logic        fire_now;
        logic        last;
    } rsp_t;

endpackage

/* sv/ordered_software_timer_manager_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_software_timer_manager_unit
// Timer table with ordered expiry, one-shot/periodic reload and compare output.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request (init, start, stop or process).
//   m_valid/m_ready/m_data return the responses: zero or more expiration
//   events in firing order, then one status response flagged with last.
//   Every response carries the compare value, armed flag and fire_now flag
//   that hold once the whole request has been applied.
//   cfg_we/cfg_wdata write tickless_mode (reset value 1); write it only idle.
// Timing:
//   One request is in flight at a time; s_ready is high only when idle.
//   A request takes an action step, then one table scan over all NUM_TIMERS
//   slots through the single shared compare unit, then a decide step.
//   A process request repeats scan, decide and fire once per timer fired.
//   Each response then passes a read step and an output step, the latter
//   held while the receiver holds m_ready low; a stall simply holds the
//   response register and the sequencer.
//   Reset clears the timer flags, stamp counter and compare state at once;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_software_timer_manager_unit
    import ostm_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int MAX_FIRES  = MAX_FIRES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int FID_AW = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;
    localparam int CNT_W  = $clog2(MAX_FIRES + 1);
    localparam int FID_D  = 2 ** FID_AW;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic   tickless_reg;

    // Per-timer flags (reset) and payload tables (no reset)
    logic [NUM_TIMERS-1:0] init_reg, active_reg, isper_reg;
    logic [63:0] period_mem [NUM_TIMERS];
    logic [63:0] expiry_mem [NUM_TIMERS];
    logic [31:0] stamp_mem  [NUM_TIMERS];
    logic [31:0] ctr_reg;

    // Fired-id buffer, replayed once compare state is final
    logic [3:0] fid_mem [FID_D];
    logic [3:0] fid_rd_reg;

    logic [TIDX_W-1:0] scan_idx_reg, best_idx_reg, rd_idx;
    logic        best_found_reg;
    logic [63:0] best_exp_reg;
    logic [31:0] best_age_reg;
    logic [CNT_W-1:0] nfired_reg, emit_cnt_reg;
    logic        status_reg;
    logic [63:0] compare_reg;
    logic        armed_reg, fire_now_reg;

    // Request decode
    logic [8:0]        id_ext;
    logic              id_ok;
    logic [TIDX_W-1:0] id_idx;
    logic [63:0]       rd_period, rd_expiry, start_when, reload_when;
    logic [31:0]       rd_age;
    logic              better, due, fire_go, scan_last;

    assign id_ext = {5'd0, req_reg.timer_id};
    assign id_ok  = id_ext < 9'(NUM_TIMERS);
    assign id_idx = id_ext[TIDX_W-1:0];

    // Single read port onto the tables: scan slot, fired head or addressed timer
    always_comb begin
        unique case (state_reg)
            ST_SCAN: rd_idx = scan_idx_reg;
            ST_FIRE: rd_idx = best_idx_reg;
            default: rd_idx = id_idx;
        endcase
    end

    assign rd_period = period_mem[rd_idx];
    assign rd_expiry = expiry_mem[rd_idx];
    assign rd_age    = ctr_reg - stamp_mem[rd_idx];

    // Shared ordering compare: earlier expiry, or same expiry and older entry
    assign better = active_reg[rd_idx] &&
                    (!best_found_reg || (rd_expiry < best_exp_reg) ||
                     ((rd_expiry == best_exp_reg) && (rd_age > best_age_reg)));

    assign start_when  = (tickless_reg && (rd_period >= HALF_RANGE)) ? ALL_ONES
                                                                     : req_reg.now + rd_period;
    assign reload_when = best_exp_reg + rd_period;
    assign scan_last   = scan_idx_reg == TIDX_W'(NUM_TIMERS - 1);
    assign due         = best_found_reg && (req_reg.now >= best_exp_reg);
    assign fire_go     = (op_t'(req_reg.op) == OP_PROCESS) && due &&
                         (nfired_reg < CNT_W'(MAX_FIRES));

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_ACT;
            ST_ACT:      state_next = ST_SCAN;
            ST_SCAN:     if (scan_last) state_next = ST_DECIDE;
            ST_DECIDE:   state_next = fire_go ? ST_FIRE : ST_RESP_RD;
            ST_FIRE:     state_next = ST_SCAN;
            ST_RESP_RD:  state_next = ST_RESP_OUT;
            ST_RESP_OUT: begin
                if (m_ready) begin
                    state_next = (emit_cnt_reg == nfired_reg) ? ST_IDLE : ST_RESP_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = state_reg == ST_RESP_OUT;

    always_comb begin
        m_data               = '0;
        m_data.kind          = emit_cnt_reg != nfired_reg;
        m_data.status        = m_data.kind ? 1'b0 : status_reg;
        m_data.fired_id      = m_data.kind ? fid_rd_reg : 4'd0;
        m_data.compare_value = compare_reg;
        m_data.compare_armed = armed_reg;
        m_data.fire_now      = fire_now_reg;
        m_data.last          = !m_data.kind;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tickless_reg <= 1'b1;
            init_reg     <= '0;
            active_reg   <= '0;
            isper_reg    <= '0;
            ctr_reg      <= '0;
            compare_reg  <= '0;
            armed_reg    <= 1'b0;
            fire_now_reg <= 1'b0;
            nfired_reg   <= '0;
            emit_cnt_reg <= '0;
            status_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                tickless_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    nfired_reg   <= '0;
                    emit_cnt_reg <= '0;
                    status_reg   <= 1'b0;
                end
                ST_ACT: begin
                    unique case (op_t'(req_reg.op))
                        OP_INIT: begin
                            if (!id_ok || req_reg.timeout == 64'd0) begin
                                status_reg <= 1'b1;
                            end else begin
                                active_reg[id_idx] <= 1'b0;
                                init_reg[id_idx]   <= 1'b1;
                                isper_reg[id_idx]  <= req_reg.periodic;
                            end
                        end
                        OP_START: begin
                            if (!id_ok || !init_reg[id_idx]) begin
                                status_reg <= 1'b1;
                            end else begin
                                active_reg[id_idx] <= 1'b1;
                                ctr_reg            <= ctr_reg + 32'd1;
                            end
                        end
                        OP_STOP: begin
                            if (!id_ok) begin
                                status_reg <= 1'b1;
                            end else begin
                                active_reg[id_idx] <= 1'b0;
                            end
                        end
                        OP_PROCESS: ;
                        default: ;
                    endcase
                end
                ST_DECIDE: begin
                    if (!fire_go) begin
                        // Final head: publish compare state
                        if (tickless_reg && best_found_reg) begin
                            compare_reg  <= best_exp_reg;
                            armed_reg    <= 1'b1;
                            fire_now_reg <= due;
                        end else begin
                            armed_reg    <= 1'b0;
                            fire_now_reg <= 1'b0;
                        end
                    end
                end
                ST_FIRE: begin
                    // Drop the head, re-arm it if periodic
                    active_reg[best_idx_reg] <= isper_reg[best_idx_reg];
                    if (isper_reg[best_idx_reg]) begin
                        ctr_reg <= ctr_reg + 32'd1;
                    end
                    nfired_reg <= nfired_reg + CNT_W'(1);
                end
                ST_RESP_OUT: begin
                    if (m_ready && emit_cnt_reg != nfired_reg) begin
                        emit_cnt_reg <= emit_cnt_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: request latch, scan tracker and timer tables
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        unique case (state_reg)
            ST_ACT: begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
                if (op_t'(req_reg.op) == OP_INIT && id_ok && req_reg.timeout != 64'd0) begin
                    period_mem[id_idx] <= req_reg.timeout;
                end
                if (op_t'(req_reg.op) == OP_START && id_ok && init_reg[id_idx]) begin
                    expiry_mem[id_idx] <= start_when;
                    stamp_mem[id_idx]  <= ctr_reg;
                end
            end
            ST_SCAN: begin
                scan_idx_reg <= scan_idx_reg + TIDX_W'(1);
                if (better) begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= rd_idx;
                    best_exp_reg   <= rd_expiry;
                    best_age_reg   <= rd_age;
                end
            end
            ST_FIRE: begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
                fid_mem[nfired_reg[FID_AW-1:0]] <= 4'(best_idx_reg);
                if (isper_reg[best_idx_reg]) begin
                    expiry_mem[best_idx_reg] <= reload_when;
                    stamp_mem[best_idx_reg]  <= ctr_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        fid_rd_reg <= fid_mem[emit_cnt_reg[FID_AW-1:0]];
    end

    // Checks
    a_idle_no_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("response while idle");
    a_fire_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        nfired_reg <= CNT_W'(MAX_FIRES)) else $error("firing cap exceeded");
    a_fire_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIRE |-> best_found_reg) else $error("fire without head");
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last |=> s_ready) else $error("no return to idle");

endmodule
